FILE: sv/saf_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and saturation helper for the soft alignment forward block
// no dependencies; compiled first

package saf_pkg;

    // fixed field widths
    localparam int VALUE_W     = 32;
    localparam int FRAMES_W    = 11;
    localparam int TOKENS_W    = 9;
    localparam int TEMP_W      = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int SP_W        = 16;

    // shared multiplier geometry
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Q16.16 value marks
    localparam logic signed [VALUE_W-1:0] UNREACH   = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0001;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAMES   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOKENS   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEMP     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_TEMP = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SCALE,
        ST_INDEX,
        ST_LOOKUP,
        ST_CORR,
        ST_SUM,
        ST_DONE
    } t_state;

    // clamp a wide sum onto the reachable range, keeping the unreachable code free
    function automatic logic signed [VALUE_W-1:0] sat_value(input logic signed [34:0] v);
        logic signed [34:0] hi_lim;
        logic signed [34:0] lo_lim;
        hi_lim = 35'sd2147483647;
        lo_lim = -35'sd2147483647;
        if (v > hi_lim) begin
            return VALUE_MAX;
        end else if (v < lo_lim) begin
            return VALUE_MIN;
        end else begin
            return v[VALUE_W-1:0];
        end
    endfunction

endpackage

FILE: sv/saf_score_if.sv
`timescale 1ns / 1ps
// score channel: valid/ready handshake carrying one Q16.16 score per beat
// depends on saf_pkg

interface saf_score_if;
    import saf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] score;

    modport source (output valid, output score, input ready);
    modport sink   (input valid, input score, output ready);
endinterface

FILE: sv/saf_alpha_if.sv
`timescale 1ns / 1ps
// result channel: valid/ready handshake carrying one alpha value and last flag per beat
// depends on saf_pkg

interface saf_alpha_if;
    import saf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] alpha_value;
    logic                      last;

    modport source (output valid, output alpha_value, output last, input ready);
    modport sink   (input valid, input alpha_value, input last, output ready);
endinterface

FILE: sv/soft_alignment_forward.sv
`timescale 1ns / 1ps
// Soft monotonic alignment forward pass over one score grid, one cell per beat.
// Scores arrive row-major on i_score; each accepted beat gives exactly one beat on
// o_alpha holding that cell's alpha (Q16.16, 0x80000000 = unreachable) and a last
// flag on the final cell, whose alpha is the partition value.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data); writing
// either length register restarts the grid at cell (0,0). Write it only while idle.
// Sequencing: i_score.ready is high only while the sequencer is idle. A row 0
// cell, a column 0 cell or a cell with an unreachable predecessor goes from DIFF
// straight to DONE; any other cell also passes SCALE, INDEX, LOOKUP, CORR and SUM:
// three passes through the one shared 32x24 multiplier (scale, table index,
// correction) plus a registered softplus table read and the final saturating add.
// The result sits in an output register, so the next beat is accepted while it
// waits; a stalled receiver holds the pipeline only when a second result is done.
// Reset (i_rst_n low, synchronous) restores the default configuration (1x1 grid,
// temperature 1.0), returns to cell (0,0) and empties the output register. The
// previous-row store has no reset; row 0 fills every column before it is read.

module soft_alignment_forward #(
    parameter int MAX_FRAMES     = 1024,
    parameter int MAX_TOKENS     = 256,
    parameter int SOFTPLUS_DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [saf_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [saf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    saf_score_if.sink                        i_score,
    saf_alpha_if.source                      o_alpha
);
    import saf_pkg::*;

    localparam int RW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int IW = $clog2(SOFTPLUS_DEPTH);
    localparam int FW = (RW + 1 > FRAMES_W) ? RW + 1 : FRAMES_W;
    localparam int TW = (CW + 1 > TOKENS_W) ? CW + 1 : TOKENS_W;

    // table step 16/SOFTPLUS_DEPTH in Q2.30
    localparam logic [63:0] SP_STEP = (64'd16 << 30) / SOFTPLUS_DEPTH;

    typedef logic [SP_W-1:0] t_sp_tab [SOFTPLUS_DEPTH];

    // restoring long division, only used while the table is built
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // softplus table ln(1+exp(-x)) for x in [0,16), Q16.16, built from Q2.30 series
    function automatic t_sp_tab build_softplus();
        t_sp_tab     tab;
        logic [63:0] h;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] q;
        logic [63:0] p;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] pw;
        logic [63:0] acc;
        logic [63:0] ln;
        h    = SP_STEP;
        sum  = 64'd1 << 30;
        term = 64'd1 << 30;
        p    = 64'd1 << 30;
        for (int n = 1; n <= 30; n++) begin
            term = div_u64((term * h) >> 30, 64'(n));
            sum  = sum + term;
        end
        q = div_u64((64'd1 << 60) + (sum >> 1), sum);
        for (int i = 0; i < SOFTPLUS_DEPTH; i++) begin
            z   = div_u64(p << 30, (64'd2 << 30) + p);
            z2  = (z * z) >> 30;
            pw  = z;
            acc = 64'd0;
            for (int k = 0; k < 16; k++) begin
                acc = acc + div_u64(pw, 64'(2 * k + 1));
                pw  = (pw * z2) >> 30;
            end
            ln     = 64'd2 * acc;
            tab[i] = SP_W'((ln + (64'd1 << 13)) >> 14);
            p      = (p * q + (64'd1 << 29)) >> 30;
        end
        return tab;
    endfunction

    localparam t_sp_tab SP_TAB = build_softplus();

    // state and configuration
    t_state                      r_state, n_state;
    logic [FRAMES_W-1:0]         r_frames;
    logic [TOKENS_W-1:0]         r_tokens;
    logic [TEMP_W-1:0]           r_temp;
    logic [TEMP_W-1:0]           r_inv;
    logic [RW-1:0]               r_row;
    logic [CW-1:0]               r_col;
    logic signed [VALUE_W-1:0]   r_mem [MAX_TOKENS];
    logic signed [VALUE_W-1:0]   r_stay;
    logic signed [VALUE_W-1:0]   r_diag;

    // datapath registers
    logic signed [VALUE_W-1:0]   r_score;
    logic signed [VALUE_W-1:0]   r_hi;
    logic [VALUE_W-1:0]          r_d;
    logic [PROD_W-1:0]           r_prod;
    logic                        r_in_range;
    logic [SP_W-1:0]             r_sp;
    logic signed [VALUE_W-1:0]   r_res;

    // output register
    logic                        r_out_valid;
    logic signed [VALUE_W-1:0]   r_out_alpha;
    logic                        r_out_last;

    // combinational
    logic                        accept;
    logic                        done_fire;
    logic                        cfg_restart;
    logic [FW-1:0]               frames_ext;
    logic [TW-1:0]               tokens_ext;
    logic [FW-1:0]               nf_eff;
    logic [TW-1:0]               ns_eff;
    logic [FW-1:0]               row_next;
    logic [TW-1:0]               col_next;
    logic                        row_end;
    logic                        col_end;
    logic                        stay_un;
    logic                        diag_un;
    logic                        fast_path;
    logic signed [VALUE_W-1:0]   add_a;
    logic signed [VALUE_W-1:0]   fast_res;
    logic                        stay_gt;
    logic signed [VALUE_W-1:0]   cmp_hi;
    logic signed [VALUE_W-1:0]   cmp_lo;
    logic signed [VALUE_W:0]     diff;
    logic [MUL_A_W-1:0]          mul_a;
    logic [MUL_B_W-1:0]          mul_b;
    logic [PROD_W-1:0]           mul_p;
    logic [40:0]                 corr_sum;
    logic signed [34:0]          corr_ext;
    logic signed [34:0]          final_sum;

    // effective lengths and end-of-row / end-of-grid detection
    assign frames_ext = FW'(r_frames);
    assign tokens_ext = TW'(r_tokens);
    assign nf_eff = (frames_ext == '0) ? FW'(1) :
                    (frames_ext > FW'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : frames_ext;
    assign ns_eff = (tokens_ext == '0) ? TW'(1) :
                    (tokens_ext > TW'(MAX_TOKENS)) ? TW'(MAX_TOKENS) : tokens_ext;
    assign row_next = FW'(r_row) + FW'(1);
    assign col_next = TW'(r_col) + TW'(1);
    assign row_end  = (row_next >= nf_eff);
    assign col_end  = (col_next >= ns_eff);

    assign accept      = i_score.valid && i_score.ready;
    assign cfg_restart = i_cfg_we && (i_cfg_index == CFG_FRAMES || i_cfg_index == CFG_TOKENS);

    // predecessor classification and the short-path result
    assign stay_un = (r_stay == UNREACH);
    assign diag_un = (r_diag == UNREACH);
    assign add_a   = (r_col == '0 || !stay_un) ? r_stay : r_diag;
    assign stay_gt = (r_stay > r_diag);
    assign cmp_hi  = stay_gt ? r_stay : r_diag;
    assign cmp_lo  = stay_gt ? r_diag : r_stay;
    assign diff    = (VALUE_W + 1)'(cmp_hi) - (VALUE_W + 1)'(cmp_lo);

    always_comb begin
        fast_path = 1'b1;
        fast_res  = UNREACH;
        priority if (r_row == '0) begin
            fast_res = (r_col == '0) ? r_score : UNREACH;
        end else if (r_col == '0) begin
            fast_res = sat_value(35'(r_stay) + 35'(r_score));
        end else if (stay_un && diag_un) begin
            fast_res = UNREACH;
        end else if (stay_un || diag_un) begin
            fast_res = sat_value(35'(add_a) + 35'(r_score));
        end else begin
            fast_path = 1'b0;
        end
    end

    // correction term, soft maximum and final saturating add
    assign corr_sum  = 41'(r_prod[40:0]) + 41'd32768;
    assign corr_ext  = {10'b0, corr_sum[40:16]};
    assign final_sum = 35'(r_hi) + corr_ext + 35'(r_score);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_score.valid) begin n_state = ST_DIFF; end
            ST_DIFF:   n_state = fast_path ? ST_DONE : ST_SCALE;
            ST_SCALE:  n_state = ST_INDEX;
            ST_INDEX:  n_state = ST_LOOKUP;
            ST_LOOKUP: n_state = ST_CORR;
            ST_CORR:   n_state = ST_SUM;
            ST_SUM:    n_state = ST_DONE;
            ST_DONE:   if (done_fire) begin n_state = ST_IDLE; end
            default:   n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake and shared multiplier operands
    always_comb begin
        i_score.ready = 1'b0;
        done_fire     = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        unique case (r_state)
            ST_IDLE: begin
                i_score.ready = 1'b1;
            end
            ST_SCALE: begin
                mul_a = r_d;
                mul_b = r_inv;
            end
            ST_INDEX: begin
                mul_a = MUL_A_W'(r_prod[35:16]);
                mul_b = MUL_B_W'(SOFTPLUS_DEPTH);
            end
            ST_CORR: begin
                mul_a = MUL_A_W'(r_sp);
                mul_b = r_temp;
            end
            ST_DONE: begin
                done_fire = !r_out_valid || o_alpha.ready;
            end
            default: begin
                done_fire = 1'b0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_frames    <= FRAMES_W'(1);
            r_tokens    <= TOKENS_W'(1);
            r_temp      <= TEMP_W'(65536);
            r_inv       <= TEMP_W'(65536);
            r_row       <= '0;
            r_col       <= '0;
            r_diag      <= UNREACH;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FRAMES:   r_frames <= i_cfg_data[FRAMES_W-1:0];
                    CFG_TOKENS:   r_tokens <= i_cfg_data[TOKENS_W-1:0];
                    CFG_TEMP:     r_temp   <= i_cfg_data[TEMP_W-1:0];
                    CFG_INV_TEMP: r_inv    <= i_cfg_data[TEMP_W-1:0];
                    default:      r_temp   <= r_temp;
                endcase
            end
            // grid position
            if (cfg_restart) begin
                r_row <= '0;
                r_col <= '0;
            end else if (done_fire) begin
                if (col_end) begin
                    r_col <= '0;
                    r_row <= row_end ? '0 : row_next[RW-1:0];
                end else begin
                    r_col <= col_next[CW-1:0];
                end
            end
            if (done_fire) begin
                r_diag <= r_stay;
            end
            // output beat bookkeeping
            if (done_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_alpha.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // previous-row store, read continuously at the current column
    always_ff @(posedge i_clk) begin
        r_stay <= r_mem[r_col];
        if (done_fire) begin
            r_mem[r_col] <= r_res;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_score <= (i_score.score == UNREACH) ? VALUE_MIN : i_score.score;
        end
        if (r_state == ST_DIFF) begin
            r_hi  <= cmp_hi;
            r_d   <= diff[VALUE_W-1:0];
            r_res <= fast_res;
        end
        if (r_state == ST_SCALE || r_state == ST_INDEX || r_state == ST_CORR) begin
            r_prod <= mul_p;
        end
        if (r_state == ST_INDEX) begin
            r_in_range <= (r_prod[PROD_W-1:36] == '0);
        end
        if (r_state == ST_LOOKUP) begin
            r_sp <= r_in_range ? SP_TAB[r_prod[20 +: IW]] : '0;
        end
        if (r_state == ST_SUM) begin
            r_res <= sat_value(final_sum);
        end
        if (done_fire) begin
            r_out_alpha <= r_res;
            r_out_last  <= col_end && row_end;
        end
    end

    assign o_alpha.valid       = r_out_valid;
    assign o_alpha.alpha_value = r_out_alpha;
    assign o_alpha.last        = r_out_last;

    // position never leaves the grid in use
    a_pos_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (FW'(r_row) < nf_eff) && (TW'(r_col) < ns_eff))
        else $error("grid position outside the configured lengths");

    // rest of row 0 is unreachable
    a_row0_unreach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_row == '0 && r_col != '0) |-> (r_res == UNREACH))
        else $error("row 0 cell beyond column 0 came out reachable");

    // column 0 below row 0 is always reachable
    a_col0_reach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_row != '0 && r_col == '0) |-> (r_res != UNREACH))
        else $error("column 0 cell came out unreachable");

    // a pending final beat means the grid has wrapped
    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_row == '0 && r_col == '0))
        else $error("position did not wrap after the final cell");

    // a long cell runs the multiplier passes in order
    a_mul_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCALE) |=> (r_state == ST_INDEX) ##1 (r_state == ST_LOOKUP)
        ##1 (r_state == ST_CORR))
        else $error("multiplier pass sequence broken");

endmodule
